>>> sv/wwlm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwlm_pkg
// Shared types and constants of the wound/wait lock manager: request and
// response payloads, table entry layouts, mode and status codes.
// ----------------------------------------------------------------------------
package wwlm_pkg;

    localparam int NUM_LOCKS    = 64;
    localparam int NUM_CONTEXTS = 16;
    localparam int STAMP_WIDTH  = 32;

    localparam int LOCK_AW = $clog2(NUM_LOCKS);
    localparam int CTX_AW  = $clog2(NUM_CONTEXTS);
    // a context never counts more locks than the table holds
    localparam int ACQ_W   = $clog2(NUM_LOCKS + 1);

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_DONE   = 3'd1,
        MODE_FINI   = 3'd2,
        MODE_LOCK   = 3'd3,
        MODE_TRY    = 3'd4,
        MODE_SLOW   = 3'd5,
        MODE_UNLOCK = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_WAIT     = 3'd1,
        STATUS_ALREADY  = 3'd2,
        STATUS_DEADLOCK = 3'd3,
        STATUS_ERROR    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] lock_id;
        logic [3:0] ctx_id;
        logic       has_ctx;
        logic [7:0] task_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] stamp_value;
        logic        wounded_holder;
        logic        held_by_task;
        logic [31:0] wound_total;
        logic [31:0] backoff_total;
    } rsp_t;

    typedef struct packed {
        logic              locked;
        logic [7:0]        owner;
        logic              hold_valid;
        logic [CTX_AW-1:0] hold_idx;
    } lock_entry_t;

    typedef struct packed {
        logic [STAMP_WIDTH-1:0] stamp;
        logic                   wounded;
        logic [ACQ_W-1:0]       acquired;
        logic                   done;
    } ctx_entry_t;

endpackage
`default_nettype wire

>>> sv/wound_wait_lock_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wound_wait_lock_manager
// Wound/wait lock manager with a lock table and an acquire context table.
// ----------------------------------------------------------------------------
// Usage:
//   A request (mode, lock, optional context, task) enters on req when
//   req_valid is high and req_stall is low. Exactly one response per request
//   leaves on rsp when rsp_valid is high and rsp_stall is low.
//   The response is registered when the request commits in the evaluate step.
//   The lock entry is read first, the holder's context entry is read from
//   the context memory in the next cycle, and the tables are written back
//   when the request commits in the evaluate step.
//   Only one request is in flight; req_stall is high until it commits.
//   While rsp_stall holds a finished response, the next request still waits
//   in the evaluate step and does not touch the tables until the output
//   register frees up.
//   Reset: all locks free and all contexts zero at once, through per-entry
//   valid bits; no clearing pass. Stamp counter restarts at 1, wound and
//   backoff totals at 0.
// ----------------------------------------------------------------------------
module wound_wait_lock_manager (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire wwlm_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output wwlm_pkg::rsp_t       rsp
);

    // tables
    wwlm_pkg::lock_entry_t lock_mem [wwlm_pkg::NUM_LOCKS];
    wwlm_pkg::ctx_entry_t  ctx_mem  [wwlm_pkg::NUM_CONTEXTS];
    logic [wwlm_pkg::NUM_LOCKS-1:0]    lock_vld_reg;
    logic [wwlm_pkg::NUM_CONTEXTS-1:0] ctx_vld_reg;

    wwlm_pkg::state_t state_reg, state_next;
    wwlm_pkg::req_t   req_reg;

    wwlm_pkg::lock_entry_t lk_raw_reg;
    logic                  lk_hit_reg;
    wwlm_pkg::ctx_entry_t  cx_raw_reg;
    logic                  cx_hit_reg;
    wwlm_pkg::ctx_entry_t  hx_raw_reg;
    logic                  hx_hit_reg;

    logic [wwlm_pkg::STAMP_WIDTH-1:0] next_stamp_reg;
    logic [31:0]                      wound_reg;
    logic [31:0]                      backoff_reg;

    wwlm_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;

    logic accept;
    logic commit;
    logic holder_rd;

    wwlm_pkg::lock_entry_t lk, lock_n, lock_after;
    wwlm_pkg::ctx_entry_t  cx, hx, ctx_n;
    logic [wwlm_pkg::CTX_AW-1:0]  ci;
    logic [wwlm_pkg::CTX_AW-1:0]  ctx_wa;
    logic [wwlm_pkg::LOCK_AW-1:0] li;
    logic lock_wr, ctx_wr, stamp_adv, wound_inc, backoff_inc;
    logic bad_mode, ctx_mode, lock_ok, ctx_ok, bad_req, stamp_show;
    logic [wwlm_pkg::STAMP_WIDTH-1:0] stamp_inc, stamp_after;
    wwlm_pkg::status_t status;
    wwlm_pkg::rsp_t    rsp_n;

    assign li     = wwlm_pkg::LOCK_AW'(req_reg.lock_id);
    assign ci     = wwlm_pkg::CTX_AW'(req_reg.ctx_id);
    assign accept = req_valid && !req_stall;

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wwlm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = wwlm_pkg::ST_LOOK;
                end
            end
            wwlm_pkg::ST_LOOK:
            begin
                state_next = wwlm_pkg::ST_EVAL;
            end
            wwlm_pkg::ST_EVAL:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = wwlm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wwlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        holder_rd = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            wwlm_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            wwlm_pkg::ST_LOOK:
            begin
                holder_rd = 1'b1;
            end
            wwlm_pkg::ST_EVAL:
            begin
                commit = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wwlm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // ------------------------------------------------------------------------
    // Memories: read registered, one write port each
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (commit && lock_wr)
        begin
            lock_mem[li] <= lock_n;
        end
        if (accept)
        begin
            lk_raw_reg <= lock_mem[wwlm_pkg::LOCK_AW'(req.lock_id)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && ctx_wr)
        begin
            ctx_mem[ctx_wa] <= ctx_n;
        end
        if (accept)
        begin
            cx_raw_reg <= ctx_mem[wwlm_pkg::CTX_AW'(req.ctx_id)];
        end
        if (holder_rd)
        begin
            hx_raw_reg <= ctx_mem[lk.hold_idx];
        end
    end

    // entries never written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_vld_reg <= '0;
            ctx_vld_reg  <= '0;
            lk_hit_reg   <= 1'b0;
            cx_hit_reg   <= 1'b0;
            hx_hit_reg   <= 1'b0;
        end
        else
        begin
            if (commit && lock_wr)
            begin
                lock_vld_reg[li] <= 1'b1;
            end
            if (commit && ctx_wr)
            begin
                ctx_vld_reg[ctx_wa] <= 1'b1;
            end
            if (accept)
            begin
                lk_hit_reg <= lock_vld_reg[wwlm_pkg::LOCK_AW'(req.lock_id)];
                cx_hit_reg <= ctx_vld_reg[wwlm_pkg::CTX_AW'(req.ctx_id)];
            end
            if (holder_rd)
            begin
                hx_hit_reg <= ctx_vld_reg[lk.hold_idx];
            end
        end
    end

    assign lk = lk_hit_reg ? lk_raw_reg : '0;
    assign cx = cx_hit_reg ? cx_raw_reg : '0;
    assign hx = hx_hit_reg ? hx_raw_reg : '0;

    // ------------------------------------------------------------------------
    // Evaluate one request
    // ------------------------------------------------------------------------
    assign stamp_inc = next_stamp_reg + 1'b1;

    always_comb
    begin
        lock_n      = lk;
        ctx_n       = cx;
        ctx_wa      = ci;
        lock_wr     = 1'b0;
        ctx_wr      = 1'b0;
        stamp_adv   = 1'b0;
        wound_inc   = 1'b0;
        backoff_inc = 1'b0;
        status      = wwlm_pkg::STATUS_OK;
        bad_mode    = 1'b0;
        ctx_mode    = 1'b0;

        case (req_reg.mode)
            wwlm_pkg::MODE_INIT,
            wwlm_pkg::MODE_DONE,
            wwlm_pkg::MODE_FINI:
            begin
                ctx_mode = 1'b1;
            end
            wwlm_pkg::MODE_LOCK,
            wwlm_pkg::MODE_TRY,
            wwlm_pkg::MODE_SLOW,
            wwlm_pkg::MODE_UNLOCK:
            begin
                ctx_mode = 1'b0;
            end
            default:
            begin
                bad_mode = 1'b1;
            end
        endcase

        lock_ok = int'(req_reg.lock_id) < wwlm_pkg::NUM_LOCKS;
        ctx_ok  = int'(req_reg.ctx_id) < wwlm_pkg::NUM_CONTEXTS;
        bad_req = bad_mode || !lock_ok || (req_reg.has_ctx && !ctx_ok) ||
                  (ctx_mode && !req_reg.has_ctx);

        if (bad_req)
        begin
            status = wwlm_pkg::STATUS_ERROR;
        end
        else
        begin
            case (req_reg.mode)
                wwlm_pkg::MODE_INIT:
                begin
                    ctx_n.stamp    = next_stamp_reg;
                    ctx_n.wounded  = 1'b0;
                    ctx_n.acquired = '0;
                    ctx_n.done     = 1'b0;
                    ctx_wr         = 1'b1;
                    stamp_adv      = 1'b1;
                end
                wwlm_pkg::MODE_DONE:
                begin
                    ctx_n.done = 1'b1;
                    ctx_wr     = 1'b1;
                end
                wwlm_pkg::MODE_FINI:
                begin
                    if (cx.acquired != '0)
                    begin
                        status = wwlm_pkg::STATUS_ERROR;
                    end
                    else
                    begin
                        ctx_n.stamp   = '0;
                        ctx_n.wounded = 1'b0;
                        ctx_n.done    = 1'b0;
                        ctx_wr        = 1'b1;
                    end
                end
                wwlm_pkg::MODE_LOCK:
                begin
                    if (req_reg.has_ctx && cx.done)
                    begin
                        status = wwlm_pkg::STATUS_ERROR;
                    end
                    else if (!lk.locked)
                    begin
                        lock_wr = 1'b1;
                        ctx_wr  = req_reg.has_ctx;
                    end
                    else if (req_reg.has_ctx && lk.hold_valid && lk.hold_idx == ci)
                    begin
                        status = wwlm_pkg::STATUS_ALREADY;
                    end
                    else
                    begin
                        // older requester wounds a younger holder
                        if (req_reg.has_ctx && lk.hold_valid &&
                            cx.stamp < hx.stamp && !hx.wounded)
                        begin
                            ctx_n         = hx;
                            ctx_n.wounded = 1'b1;
                            ctx_wa        = lk.hold_idx;
                            ctx_wr        = 1'b1;
                            wound_inc     = 1'b1;
                        end
                        if (req_reg.has_ctx && cx.wounded)
                        begin
                            backoff_inc = 1'b1;
                            status      = wwlm_pkg::STATUS_DEADLOCK;
                        end
                        else
                        begin
                            status = wwlm_pkg::STATUS_WAIT;
                        end
                    end
                end
                wwlm_pkg::MODE_TRY:
                begin
                    if (!lk.locked)
                    begin
                        lock_wr = 1'b1;
                        ctx_wr  = req_reg.has_ctx;
                    end
                    else
                    begin
                        status = wwlm_pkg::STATUS_WAIT;
                    end
                end
                wwlm_pkg::MODE_SLOW:
                begin
                    ctx_n.wounded = 1'b0;
                    ctx_wr        = req_reg.has_ctx;
                    if (!lk.locked)
                    begin
                        lock_wr = 1'b1;
                    end
                    else
                    begin
                        status = wwlm_pkg::STATUS_WAIT;
                    end
                end
                wwlm_pkg::MODE_UNLOCK:
                begin
                    if (lk.hold_valid && hx.acquired != '0)
                    begin
                        ctx_n          = hx;
                        ctx_n.acquired = wwlm_pkg::ACQ_W'(hx.acquired - 1'b1);
                        ctx_wa         = lk.hold_idx;
                        ctx_wr         = 1'b1;
                    end
                    lock_n  = '0;
                    lock_wr = 1'b1;
                end
                default:
                begin
                    status = wwlm_pkg::STATUS_ERROR;
                end
            endcase

            // grab of a free lock: record owner and bump the context count
            if (lock_wr && req_reg.mode != wwlm_pkg::MODE_UNLOCK)
            begin
                lock_n.locked     = 1'b1;
                lock_n.owner      = req_reg.task_id;
                lock_n.hold_valid = req_reg.has_ctx;
                lock_n.hold_idx   = req_reg.has_ctx ? ci : '0;
                if (req_reg.has_ctx)
                begin
                    ctx_n.acquired = wwlm_pkg::ACQ_W'(ctx_n.acquired + 1'b1);
                end
            end
        end

        stamp_after = (ctx_wr && ctx_wa == ci) ? ctx_n.stamp : cx.stamp;
        stamp_show  = req_reg.has_ctx && ctx_ok && lock_ok && !bad_mode;
        lock_after  = lock_wr ? lock_n : lk;

        rsp_n.status         = status;
        rsp_n.stamp_value    = stamp_show ? 32'(stamp_after) : '0;
        rsp_n.wounded_holder = wound_inc;
        rsp_n.held_by_task   = lock_ok && lock_after.locked &&
                               lock_after.owner == req_reg.task_id;
        rsp_n.wound_total    = wound_reg + 32'(wound_inc);
        rsp_n.backoff_total  = backoff_reg + 32'(backoff_inc);
    end

    // ------------------------------------------------------------------------
    // Counters and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_stamp_reg <= wwlm_pkg::STAMP_WIDTH'(1);
            wound_reg      <= '0;
            backoff_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                wound_reg   <= rsp_n.wound_total;
                backoff_reg <= rsp_n.backoff_total;
                if (stamp_adv)
                begin
                    // skip zero on wrap
                    next_stamp_reg <= (stamp_inc == '0) ? wwlm_pkg::STAMP_WIDTH'(1)
                                                        : stamp_inc;
                end
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= rsp_n;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_stamp_reg != '0)
        else $error("stamp counter reached zero");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == wwlm_pkg::ST_LOOK)
        else $error("accepted request did not start a table lookup");

    a_look_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wwlm_pkg::ST_LOOK |=> state_reg == wwlm_pkg::ST_EVAL)
        else $error("holder read did not lead to evaluation");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid && rsp.wound_total == wound_reg)
        else $error("committed request did not show its response");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(wound_reg) && $stable(backoff_reg))
        else $error("totals moved without a committed request");
`endif

endmodule
`default_nettype wire
